[rtl/core/claq_pkg.sv]
// ----------------------------------------------------------------------------
// claq_pkg: shared types and constants of the argument quoter
// Holds the byte codes, the command record that passes from the front end to
// the back end, the queue status record and the back end phase type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package claq_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned RUN_W      = 5;   // pending backslash run count
   localparam int unsigned SLASH_W    = 6;   // up to twice the run plus one
   localparam int unsigned RUN_CAP    = 30;  // hard cap on the run limit
   localparam int unsigned MAX_RUN_DEFAULT = 30;
   localparam int unsigned CMDQ_DEPTH = 2;

   localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

   // One unit of output work: an optional opening quote, a number of
   // backslashes, then an optional final byte.
   typedef struct packed {
      logic               need_open;
      logic [SLASH_W-1:0] slashes;
      logic               has_char;
      logic [BYTE_W-1:0]  ch;
      logic               last;
      logic               ovf;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cmdq_status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_OPEN,
      PH_SLASH,
      PH_CHAR
   } phase_type;

endpackage

`default_nettype wire

[rtl/core/command_line_arg_quoter.sv]
// Path: with the writer idle, a byte that produces output passes the queue, the writer phase
//   register and the output register before its first result byte shows.
// Throughput: one result byte per cycle from the byte writer while it has work and the result
//   channel is not stalled; input bytes are taken while the command queue is not full.
// Reset: synchronous, active high; clears the run count, flags, queue and output valid.
//   No clearing pass is needed, so the block is ready in the cycle after reset falls.
// ----------------------------------------------------------------------------
// command_line_arg_quoter: wraps an argument in double quotes
// Backslashes escape only before a quote: a run of backslashes is held as a
// count and written doubled before a quote or the closing quote, unchanged
// before any other byte. A quote inside the argument gets one extra
// backslash. A zero byte ends the argument and yields the closing quote.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module command_line_arg_quoter #(
   // Longest backslash run kept; longer runs drop the extra backslashes and
   // raise the sticky overflow flag. Values above thirty act as thirty.
   parameter int unsigned MAX_RUN = claq_pkg::MAX_RUN_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Input channel: one argument byte per transaction.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [claq_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] byte_in
   // Result channel: one byte of the quoted argument per transaction.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [claq_pkg::BYTE_W-1:0]        rsp_tdata,   // [7:0] byte_out
   output logic                               rsp_tlast,   // end_of_arg
   output logic [0:0]                         rsp_tuser    // [0] run_overflow
);

   // The classifier turns every byte into at most one command; the queue
   // lets it keep taking bytes while the writer is busy with a long run.
   claq_pkg::cmd_type          push_cmd;
   claq_pkg::cmd_type          head_cmd;
   claq_pkg::cmdq_status_type  q_status;
   logic                       push;
   logic                       pop;

   claq_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   claq_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // The writer emits the opening quote, the backslashes and the final byte
   // of each command in turn, and moves straight on to the next command.
   claq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[rtl/core/claq_front.sv]
// ----------------------------------------------------------------------------
// claq_front: input classifier
// Accepts argument bytes, tracks the pending backslash run and the sticky
// overflow flag, and turns each byte into a command for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module claq_front #(
   parameter int unsigned MAX_RUN = claq_pkg::MAX_RUN_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [claq_pkg::BYTE_W-1:0]   req_tdata,
   input  wire claq_pkg::cmdq_status_type     q_status,
   output logic                               push,
   output claq_pkg::cmd_type                  push_cmd
);

   localparam int unsigned LIMIT_INT =
      (MAX_RUN > claq_pkg::RUN_CAP) ? claq_pkg::RUN_CAP : MAX_RUN;
   localparam logic [claq_pkg::RUN_W-1:0] RUN_LIMIT = claq_pkg::RUN_W'(LIMIT_INT);

   logic [claq_pkg::RUN_W-1:0] pending_ff, pending_in;
   logic                       opened_ff, opened_in;
   logic                       overflow_ff, overflow_in;

   logic                       accept;
   logic [claq_pkg::RUN_W-1:0] run;
   logic                       is_bslash, is_quote, is_nul;

   always_comb begin
      req_tready = !q_status.full;
      accept     = req_tvalid && req_tready;
      is_bslash  = (req_tdata == claq_pkg::CH_BSLASH);
      is_quote   = (req_tdata == claq_pkg::CH_QUOTE);
      is_nul     = (req_tdata == claq_pkg::CH_NUL);
      run        = (pending_ff > RUN_LIMIT) ? RUN_LIMIT : pending_ff;

      push_cmd.need_open = !opened_ff;
      push_cmd.has_char  = !is_bslash;
      push_cmd.ovf       = overflow_ff;
      push_cmd.last      = is_nul;
      if (is_quote) begin
         push_cmd.slashes = {run, 1'b1};
         push_cmd.ch      = claq_pkg::CH_QUOTE;
      end else if (is_nul) begin
         push_cmd.slashes = {run, 1'b0};
         push_cmd.ch      = claq_pkg::CH_QUOTE;
      end else if (is_bslash) begin
         push_cmd.slashes = '0;
         push_cmd.ch      = req_tdata;
      end else begin
         push_cmd.slashes = {1'b0, run};
         push_cmd.ch      = req_tdata;
      end
      push = accept && (!opened_ff || !is_bslash);

      pending_in  = pending_ff;
      opened_in   = opened_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         opened_in = !is_nul;
         if (is_bslash) begin
            if (run < RUN_LIMIT) begin
               pending_in = run + claq_pkg::RUN_W'(1);
            end else begin
               pending_in  = run;
               overflow_in = 1'b1;
            end
         end else begin
            pending_in = '0;
            if (is_nul) begin
               overflow_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         opened_ff   <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         opened_ff   <= opened_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/claq_cmdq.sv]
// ----------------------------------------------------------------------------
// claq_cmdq: command queue
// A short register queue that decouples the classifier from the byte writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module claq_cmdq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire claq_pkg::cmd_type         push_cmd,
   input  wire logic                      pop,
   output claq_pkg::cmd_type              head_cmd,
   output claq_pkg::cmdq_status_type      status
);

   localparam int unsigned DEPTH = claq_pkg::CMDQ_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   claq_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == CNT_FULL);
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head_cmd     = entries_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/core/claq_back.sv]
// ----------------------------------------------------------------------------
// claq_back: byte writer
// Expands each command into its output bytes, one per cycle while the result
// channel is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module claq_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire claq_pkg::cmd_type             head_cmd,
   input  wire claq_pkg::cmdq_status_type     q_status,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [claq_pkg::BYTE_W-1:0]        rsp_tdata,
   output logic                               rsp_tlast,
   output logic [0:0]                         rsp_tuser
);

   claq_pkg::phase_type          phase_ff, phase_in, phase_step;
   claq_pkg::cmd_type            cur_ff, cur_in;
   logic [claq_pkg::SLASH_W-1:0] left_ff, left_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [claq_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic                         produce;
   logic                         finishing;
   logic [claq_pkg::BYTE_W-1:0]  emit_byte;
   logic                         emit_last;

   always_comb begin
      produce    = (phase_ff != claq_pkg::PH_IDLE) && (!rsp_valid_ff || rsp_tready);
      emit_byte  = claq_pkg::CH_QUOTE;
      emit_last  = 1'b0;
      phase_step = phase_ff;
      left_in    = left_ff;
      cur_in     = cur_ff;

      case (phase_ff)
         claq_pkg::PH_OPEN: begin
            if (cur_ff.slashes != '0) begin
               phase_step = claq_pkg::PH_SLASH;
            end else if (cur_ff.has_char) begin
               phase_step = claq_pkg::PH_CHAR;
            end else begin
               phase_step = claq_pkg::PH_IDLE;
            end
         end
         claq_pkg::PH_SLASH: begin
            emit_byte = claq_pkg::CH_BSLASH;
            if (left_ff == claq_pkg::SLASH_W'(1)) begin
               phase_step = cur_ff.has_char ? claq_pkg::PH_CHAR : claq_pkg::PH_IDLE;
            end
         end
         claq_pkg::PH_CHAR: begin
            emit_byte  = cur_ff.ch;
            emit_last  = cur_ff.last;
            phase_step = claq_pkg::PH_IDLE;
         end
         default: begin
            phase_step = claq_pkg::PH_IDLE;
         end
      endcase

      phase_in = phase_ff;
      if (produce) begin
         phase_in = phase_step;
         if (phase_ff == claq_pkg::PH_SLASH) begin
            left_in = left_ff - claq_pkg::SLASH_W'(1);
         end
      end

      finishing = (phase_ff == claq_pkg::PH_IDLE) ||
                  (produce && (phase_step == claq_pkg::PH_IDLE));
      pop = finishing && !q_status.empty;
      if (pop) begin
         cur_in  = head_cmd;
         left_in = head_cmd.slashes;
         if (head_cmd.need_open) begin
            phase_in = claq_pkg::PH_OPEN;
         end else if (head_cmd.slashes != '0) begin
            phase_in = claq_pkg::PH_SLASH;
         end else if (head_cmd.has_char) begin
            phase_in = claq_pkg::PH_CHAR;
         end else begin
            phase_in = claq_pkg::PH_IDLE;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = emit_last;
         rsp_ovf_in   = cur_ff.ovf;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_byte_ff;
      rsp_tlast  = rsp_last_ff;
      rsp_tuser  = rsp_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= claq_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // A backslash phase always has at least one backslash left to write.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == claq_pkg::PH_SLASH |-> left_ff != '0)
      else $error("backslash phase entered with no backslashes left");

   // The end-of-argument mark only ever sits on a closing quote.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_byte_ff == claq_pkg::CH_QUOTE)
      else $error("end of argument flagged on a byte other than a quote");

   // Commands are only taken from the queue when it holds one.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("command popped from an empty queue");

   // A stalled result is never overwritten by a new byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !produce)
      else $error("output byte produced while the held result is stalled");

endmodule

`default_nettype wire
